@@ rtl/mm_pkg.sv @@
package mm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 2 * VAL_W;
    localparam int CFG_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_WR_FIRST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_SECOND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_SECOND = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] ROWS_FIRST_RST  = 4'd6;
    localparam logic [CFG_W-1:0] INNER_SIZE_RST  = 4'd6;
    localparam logic [CFG_W-1:0] COLS_SECOND_RST = 4'd1;

    // Saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // Control for one term entering the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

@@ rtl/mm_if.sv @@
interface mm_item_if;
    logic                                     valid;
    logic                                     ready;
    logic        [mm_pkg::ACT_W-1:0]          action;
    logic        [mm_pkg::IDX_W-1:0]          row_index;
    logic        [mm_pkg::IDX_W-1:0]          col_index;
    logic signed [mm_pkg::VAL_W-1:0]          element_value;

    modport source (output valid, action, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, action, row_index, col_index, element_value,
                    output ready);
endinterface

interface mm_result_if;
    logic                                     valid;
    logic                                     ready;
    logic        [mm_pkg::IDX_W-1:0]          out_row;
    logic        [mm_pkg::IDX_W-1:0]          out_col;
    logic signed [mm_pkg::VAL_W-1:0]          product_value;
    logic                                     last;

    modport source (output valid, out_row, out_col, product_value, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, product_value, last,
                    output ready);
endinterface

@@ rtl/mm_store.sv @@
module mm_store #(
    parameter int DEPTH = mm_pkg::MAX_DIM_DEF * mm_pkg::MAX_DIM_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic signed [mm_pkg::VAL_W-1:0] wr_data,
    input  logic [AW-1:0]                   rd_addr,
    output logic signed [mm_pkg::VAL_W-1:0] rd_data
);

    logic signed [mm_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [mm_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/mm_mac.sv @@
module mm_mac #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mm_pkg::mac_ctl_t                ctl,
    input  logic signed [mm_pkg::VAL_W-1:0] a_data,
    input  logic signed [mm_pkg::VAL_W-1:0] b_data,
    output logic                            res_done,
    output logic signed [mm_pkg::VAL_W-1:0] res_value
);

    // Room for the exact sum of MAX_DIM full products
    localparam int ACC_W = mm_pkg::PROD_W + $clog2(MAX_DIM);
    localparam int VW    = mm_pkg::VAL_W;

    mm_pkg::mac_ctl_t ctl_d1_reg;
    mm_pkg::mac_ctl_t ctl_d2_reg;
    logic             acc_done_reg;
    logic             res_done_reg;

    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic signed [ACC_W-1:0]          shifted;
    logic        [ACC_W-VW:0]         upper;
    logic signed [VW-1:0]             res_reg;
    logic signed [VW-1:0]             res_next;

    assign prod_next = mm_pkg::PROD_W'(a_data) * mm_pkg::PROD_W'(b_data);
    assign acc_next  = (ctl_d2_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    // Floor shift, then clamp to the signed word range
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        upper   = shifted[ACC_W-1:VW-1];
        if ((&upper) || !(|upper))
        begin
            res_next = shifted[VW-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            res_next = mm_pkg::VAL_MIN;
        end
        else
        begin
            res_next = mm_pkg::VAL_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg   <= '0;
            ctl_d2_reg   <= '0;
            acc_done_reg <= 1'b0;
            res_done_reg <= 1'b0;
        end
        else
        begin
            ctl_d1_reg   <= ctl;
            ctl_d2_reg   <= ctl_d1_reg;
            acc_done_reg <= ctl_d2_reg.valid && ctl_d2_reg.last;
            res_done_reg <= acc_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_d1_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctl_d2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        // Hold the result until the next element completes
        if (acc_done_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_done  = res_done_reg;
    assign res_value = res_reg;

endmodule

@@ rtl/matrix_multiply.sv @@
// Channel   Dir   Handshake      Payload
// item      in    valid/ready    action, row_index, col_index, element_value
// result    out   valid/ready    out_row, out_col, product_value, last
// cfg       in    cfg_write      cfg_index, cfg_data
//
// A write item is stored as it is accepted. A compute item holds the block for
// rows * cols elements of inner_size terms each: one multiply-accumulate
// term per cycle through the shared MAC, then the read, multiply, add and clamp
// registers. A stalled result holds the next element in the MAC until taken.
// Reset initializes control and configuration; operand stores are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mm_item_if.sink                        item,
    mm_result_if.source                    result,
    input  logic                           cfg_write,
    input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0] seq_reg;
    logic [1:0] seq_next;

    logic [mm_pkg::CFG_W-1:0] rows_reg;
    logic [mm_pkg::CFG_W-1:0] inner_reg;
    logic [mm_pkg::CFG_W-1:0] cols_reg;

    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] x_next;

    logic [DIM_W-1:0] m_dim;
    logic [DIM_W-1:0] k_dim;
    logic [DIM_W-1:0] n_dim;
    logic             last_i;
    logic             last_j;
    logic             last_x;

    logic             accept;
    logic             in_range;
    logic [CW-1:0]    wr_row;
    logic [CW-1:0]    wr_col;
    logic [AW-1:0]    wr_addr;
    logic             wr_first;
    logic             wr_second;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;

    logic signed [mm_pkg::VAL_W-1:0] a_data;
    logic signed [mm_pkg::VAL_W-1:0] b_data;
    mm_pkg::mac_ctl_t                mac_ctl;
    logic                            res_done;
    logic signed [mm_pkg::VAL_W-1:0] res_value;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_load;
    logic [mm_pkg::IDX_W-1:0]        out_row_reg;
    logic [mm_pkg::IDX_W-1:0]        out_col_reg;
    logic signed [mm_pkg::VAL_W-1:0] out_value_reg;
    logic                            out_last_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0)
        begin
            d = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            d = DIM_W'(MAX_DIM);
        end
        else
        begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign m_dim = clamp_dim(rows_reg);
    assign k_dim = clamp_dim(inner_reg);
    assign n_dim = clamp_dim(cols_reg);

    assign last_i = (DIM_W'(i_reg) + DIM_W'(1)) == m_dim;
    assign last_j = (DIM_W'(j_reg) + DIM_W'(1)) == n_dim;
    assign last_x = (DIM_W'(x_reg) + DIM_W'(1)) == k_dim;

    // Item side: writes go straight to the stores
    assign item.ready = (seq_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign in_range   = (32'(item.row_index) < MAX_DIM) && (32'(item.col_index) < MAX_DIM);
    assign wr_row     = CW'(item.row_index);
    assign wr_col     = CW'(item.col_index);
    assign wr_addr    = AW'(wr_row) * ROW_STRIDE + AW'(wr_col);
    assign wr_first   = accept && in_range && (item.action == mm_pkg::ACT_WR_FIRST);
    assign wr_second  = accept && in_range && (item.action == mm_pkg::ACT_WR_SECOND);

    assign rd_addr_a = AW'(i_reg) * ROW_STRIDE + AW'(x_reg);
    assign rd_addr_b = AW'(x_reg) * ROW_STRIDE + AW'(j_reg);

    assign mac_ctl.valid = (seq_reg == ST_ISSUE);
    assign mac_ctl.first = (x_reg == '0);
    assign mac_ctl.last  = last_x;

    mm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_first_store (
        .clk     (clk),
        .wr_en   (wr_first),
        .wr_addr (wr_addr),
        .wr_data (item.element_value),
        .rd_addr (rd_addr_a),
        .rd_data (a_data)
    );

    mm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_second_store (
        .clk     (clk),
        .wr_en   (wr_second),
        .wr_addr (wr_addr),
        .wr_data (item.element_value),
        .rd_addr (rd_addr_b),
        .rd_data (b_data)
    );

    mm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .a_data    (a_data),
        .b_data    (b_data),
        .res_done  (res_done),
        .res_value (res_value)
    );

    // Sequencer: walk the product row-major, one element at a time
    always_comb
    begin
        seq_next = seq_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        x_next   = x_reg;
        out_load = 1'b0;
        case (seq_reg)
            ST_IDLE:
            begin
                if (accept && (item.action == mm_pkg::ACT_COMPUTE))
                begin
                    i_next   = '0;
                    j_next   = '0;
                    x_next   = '0;
                    seq_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (last_x)
                begin
                    x_next   = '0;
                    seq_next = ST_WAIT;
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
            end
            ST_WAIT:
            begin
                if (res_done)
                begin
                    seq_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            seq_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next   = i_reg + CW'(1);
                            seq_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        j_next   = j_reg + CW'(1);
                        seq_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            x_reg         <= '0;
            out_valid_reg <= 1'b0;
            rows_reg      <= mm_pkg::ROWS_FIRST_RST;
            inner_reg     <= mm_pkg::INNER_SIZE_RST;
            cols_reg      <= mm_pkg::COLS_SECOND_RST;
        end
        else
        begin
            seq_reg       <= seq_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            x_reg         <= x_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    mm_pkg::REG_ROWS_FIRST:  rows_reg  <= cfg_data;
                    mm_pkg::REG_INNER_SIZE:  inner_reg <= cfg_data;
                    mm_pkg::REG_COLS_SECOND: cols_reg  <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= mm_pkg::IDX_W'(i_reg);
            out_col_reg   <= mm_pkg::IDX_W'(j_reg);
            out_value_reg <= res_value;
            out_last_reg  <= last_i && last_j;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.product_value = out_value_reg;
    assign result.last          = out_last_reg;

endmodule
